### hw/rtl/ddma_pkg.sv
// Shared types and constants for the dual DMA controller with page registers.
// Holds command codes, register numbers, page port numbers and the structs
// that pass between the decoder, the core and the top level.
package ddma_pkg;

  // Commands carried with each input word.
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_XFER  = 2'd2;

  // Controller register numbers above the address/count block.
  localparam logic [3:0] REG_CMD       = 4'd8;
  localparam logic [3:0] REG_REQ       = 4'd9;
  localparam logic [3:0] REG_MASK      = 4'd10;
  localparam logic [3:0] REG_MODE      = 4'd11;
  localparam logic [3:0] REG_CLR_BP    = 4'd12;
  localparam logic [3:0] REG_MCLR      = 4'd13;
  localparam logic [3:0] REG_CLR_MASKS = 4'd14;
  localparam logic [3:0] REG_ALL_MASKS = 4'd15;

  // Page register ports.
  localparam logic [7:0] PAGE_PORT_CH0 = 8'h87;
  localparam logic [7:0] PAGE_PORT_CH1 = 8'h83;
  localparam logic [7:0] PAGE_PORT_CH2 = 8'h81;
  localparam logic [7:0] PAGE_PORT_CH3 = 8'h82;
  localparam logic [7:0] PAGE_PORT_CH5 = 8'h8B;
  localparam logic [7:0] PAGE_PORT_CH6 = 8'h89;
  localparam logic [7:0] PAGE_PORT_CH7 = 8'h8A;

  // Value returned by ports with nothing behind them.
  localparam logic [7:0] UNMAPPED_DATA = 8'hFF;

  // Mode register bits.
  localparam int MODE_AUTOINIT_BIT  = 4;
  localparam int MODE_DECREMENT_BIT = 5;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] port;
    logic [7:0] write_data;
    logic [2:0] channel;
  } item_t;

  // Port decode result.
  typedef struct packed {
    logic       page_range;  // port in 0x80-0x8F
    logic       page_hit;    // port is one of the seven page registers
    logic [2:0] page_ch;
    logic       reg_hit;     // port maps to a controller register
    logic       ctl;         // 0 first controller, 1 second controller
    logic [3:0] regno;
  } dec_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [23:0] phys_addr;
    logic        transferred;
    logic [1:0]  unit_bytes;
    logic        terminal_count;
    logic        channel_stopped;
    logic [17:0] remaining_bytes;
  } res_t;

endpackage

### hw/rtl/ddma_decode.sv
// Port decoder for the dual DMA controller.
// Maps an I/O port number to a page register or a controller register.
// Depends on ddma_pkg.
module ddma_decode (
  input  logic [7:0]    port,
  output ddma_pkg::dec_t dec
);

  // Page register lookup over the non-sequential page map.
  always_comb begin
    dec = '0;
    dec.page_range = (port[7:4] == 4'h8);
    dec.page_hit = 1'b1;
    case (port)
      ddma_pkg::PAGE_PORT_CH0: dec.page_ch = 3'd0;
      ddma_pkg::PAGE_PORT_CH1: dec.page_ch = 3'd1;
      ddma_pkg::PAGE_PORT_CH2: dec.page_ch = 3'd2;
      ddma_pkg::PAGE_PORT_CH3: dec.page_ch = 3'd3;
      ddma_pkg::PAGE_PORT_CH5: dec.page_ch = 3'd5;
      ddma_pkg::PAGE_PORT_CH6: dec.page_ch = 3'd6;
      ddma_pkg::PAGE_PORT_CH7: dec.page_ch = 3'd7;
      default: begin
        dec.page_ch  = 3'd0;
        dec.page_hit = 1'b0;
      end
    endcase

    // The first controller sits at 0x00-0x0F, the second at 0xC0-0xDF
    // where each even/odd port pair aliases one register.
    if (port[7:4] == 4'h0) begin
      dec.reg_hit = 1'b1;
      dec.ctl     = 1'b0;
      dec.regno   = port[3:0];
    end else if (port[7:5] == 3'b110) begin
      dec.reg_hit = 1'b1;
      dec.ctl     = 1'b1;
      dec.regno   = port[4:1];
    end
  end

endmodule

### hw/rtl/ddma_core.sv
// Register file and single-pass execution logic of the dual DMA controller.
// Holds all channel state, forms the result of one word and updates state.
// Depends on ddma_pkg.
module ddma_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  ddma_pkg::item_t item,
  input  ddma_pkg::dec_t  dec,
  output ddma_pkg::res_t  res
);

  logic [15:0] base_address [8];
  logic [15:0] load_count [8];
  logic [15:0] current_address [8];
  logic [15:0] current_count [8];
  logic [7:0]  page_value [8];
  logic [7:0]  mode_value [8];
  logic [7:0]  mask_bit;
  logic [7:0]  tc_bit;
  logic [1:0]  byte_pointer;

  logic        is_xfer;
  logic [2:0]  idx;
  logic [2:0]  sel_ch;
  logic        bp;
  logic [15:0] ca;
  logic [15:0] cc;
  logic [15:0] ba;
  logic [15:0] bc;
  logic [7:0]  pg;
  logic [7:0]  md;
  logic        live;
  logic        word;
  logic        at_tc;
  logic        autoinit;
  logic [15:0] addr_step;
  logic [15:0] addr_after;
  logic [15:0] count_after;
  logic [16:0] count_plus;
  logic [15:0] new_half_a;
  logic [15:0] new_half_c;
  logic [3:0]  ctl_tc;

  // One channel is addressed per word: the transfer channel or the register's.
  assign is_xfer = (item.command == ddma_pkg::CMD_XFER);
  assign idx     = is_xfer ? item.channel : {dec.ctl, dec.regno[2:1]};
  assign sel_ch  = {dec.ctl, item.write_data[1:0]};
  assign bp      = byte_pointer[dec.ctl];
  assign ca      = current_address[idx];
  assign cc      = current_count[idx];
  assign ba      = base_address[idx];
  assign bc      = load_count[idx];
  assign pg      = page_value[idx];
  assign md      = mode_value[idx];
  assign ctl_tc  = dec.ctl ? tc_bit[7:4] : tc_bit[3:0];

  // Byte-pointer merge for address and count writes.
  assign new_half_a = bp ? {item.write_data, ba[7:0]} : {ba[15:8], item.write_data};
  assign new_half_c = bp ? {item.write_data, bc[7:0]} : {bc[15:8], item.write_data};

  // Transfer step.
  assign live      = is_xfer && !mask_bit[idx];
  assign word      = idx[2];
  assign at_tc     = (cc == 16'd0);
  assign autoinit  = md[ddma_pkg::MODE_AUTOINIT_BIT];
  assign addr_step = md[ddma_pkg::MODE_DECREMENT_BIT] ? (ca - 16'd1) : (ca + 16'd1);

  // Autoinit at terminal count reloads the address from base instead of stepping.
  assign addr_after = (at_tc && autoinit) ? ba : addr_step;

  always_comb begin
    if (!live) begin
      count_after = cc;
    end else if (at_tc) begin
      count_after = autoinit ? bc : cc;
    end else begin
      count_after = cc - 16'd1;
    end
  end

  assign count_plus = {1'b0, count_after} + 17'd1;

  // Result of the word.
  always_comb begin
    res = '0;
    case (item.command)
      ddma_pkg::CMD_READ: begin
        if (dec.page_range) begin
          res.read_data = dec.page_hit ? page_value[dec.page_ch] : ddma_pkg::UNMAPPED_DATA;
        end else if (dec.reg_hit && !dec.regno[3]) begin
          if (dec.regno[0]) begin
            res.read_data = bp ? cc[15:8] : cc[7:0];
          end else begin
            res.read_data = bp ? ca[15:8] : ca[7:0];
          end
        end else if (dec.reg_hit && dec.regno == ddma_pkg::REG_CMD) begin
          res.read_data = {4'd0, ctl_tc};
        end else begin
          res.read_data = ddma_pkg::UNMAPPED_DATA;
        end
      end
      ddma_pkg::CMD_XFER: begin
        if (live) begin
          res.phys_addr       = word ? {pg[7:1], ca, 1'b0} : {pg, ca};
          res.transferred     = 1'b1;
          res.unit_bytes      = word ? 2'd2 : 2'd1;
          res.terminal_count  = at_tc;
          res.channel_stopped = at_tc && !autoinit;
        end
        res.remaining_bytes = word ? {count_plus, 1'b0} : {1'b0, count_plus};
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // State update when the word leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        base_address[i]    <= '0;
        load_count[i]      <= '0;
        current_address[i] <= '0;
        current_count[i]   <= '0;
        page_value[i]      <= '0;
        mode_value[i]      <= '0;
      end
      mask_bit     <= '1;
      tc_bit       <= '0;
      byte_pointer <= '0;
    end else if (fire) begin
      case (item.command)
        ddma_pkg::CMD_WRITE: begin
          if (dec.page_range) begin
            if (dec.page_hit) begin
              page_value[dec.page_ch] <= item.write_data;
            end
          end else if (dec.reg_hit && !dec.regno[3]) begin
            if (dec.regno[0]) begin
              load_count[idx]    <= new_half_c;
              current_count[idx] <= new_half_c;
            end else begin
              base_address[idx]    <= new_half_a;
              current_address[idx] <= new_half_a;
            end
            byte_pointer[dec.ctl] <= !bp;
          end else if (dec.reg_hit) begin
            case (dec.regno)
              ddma_pkg::REG_MASK: mask_bit[sel_ch] <= item.write_data[2];
              ddma_pkg::REG_MODE: mode_value[sel_ch] <= item.write_data;
              ddma_pkg::REG_CLR_BP: byte_pointer[dec.ctl] <= 1'b0;
              ddma_pkg::REG_MCLR: begin
                byte_pointer[dec.ctl] <= 1'b0;
                if (dec.ctl) begin
                  mask_bit[7:4] <= '1;
                  tc_bit[7:4]   <= '0;
                end else begin
                  mask_bit[3:0] <= '1;
                  tc_bit[3:0]   <= '0;
                end
              end
              ddma_pkg::REG_CLR_MASKS: begin
                if (dec.ctl) mask_bit[7:4] <= '0;
                else mask_bit[3:0] <= '0;
              end
              ddma_pkg::REG_ALL_MASKS: begin
                if (dec.ctl) mask_bit[7:4] <= item.write_data[3:0];
                else mask_bit[3:0] <= item.write_data[3:0];
              end
              default: begin
              end
            endcase
          end
        end
        ddma_pkg::CMD_READ: begin
          if (!dec.page_range && dec.reg_hit && !dec.regno[3]) begin
            byte_pointer[dec.ctl] <= !bp;
          end else if (!dec.page_range && dec.reg_hit && dec.regno == ddma_pkg::REG_CMD) begin
            if (dec.ctl) tc_bit[7:4] <= '0;
            else tc_bit[3:0] <= '0;
          end
        end
        ddma_pkg::CMD_XFER: begin
          if (live) begin
            current_address[idx] <= addr_after;
            current_count[idx]   <= count_after;
            if (at_tc) begin
              tc_bit[idx] <= 1'b1;
              if (!autoinit) begin
                mask_bit[idx] <= 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // A channel that stops at terminal count is masked afterwards.
  a_stop_masks: assert property (@(posedge clk) disable iff (rst)
    fire && res.channel_stopped |=> mask_bit[$past(idx)])
    else $error("stopped channel not masked");

  // Terminal count on a live transfer always sets that channel's TC bit.
  a_tc_sets: assert property (@(posedge clk) disable iff (rst)
    fire && res.terminal_count |=> tc_bit[$past(idx)])
    else $error("terminal count did not set TC bit");

  // Autoinit at terminal count reloads the count from base.
  a_reload: assert property (@(posedge clk) disable iff (rst)
    fire && res.terminal_count && !res.channel_stopped
    |=> current_count[$past(idx)] == load_count[$past(idx)])
    else $error("autoinit reload failed");
`endif

endmodule

### hw/rtl/dual_dma_controller_with_page_registers.sv
// Top level of the dual DMA controller with AT page registers.
// Input register, port decoder, core and result register.
// Depends on ddma_pkg, ddma_decode and ddma_core.
//
//   Channel  Direction  Handshake            Fields
//   in       to block   in_valid/in_ready    command, port, write_data, channel
//   out      from block out_valid/out_ready  read_data, phys_addr, transferred,
//                                            unit_bytes, terminal_count,
//                                            channel_stopped, remaining_bytes
//
// Every word yields one result; it passes the input register and then the result register.
// One word per cycle is sustained while out_ready stays high: the core reads the channel
// registers between the input and result registers and updates them as the word moves on.
// While out_ready is low, one more word is taken into the input register
// and then in_ready drops until the result register frees.
// rst is synchronous: every channel comes out masked with all registers zero.
module dual_dma_controller_with_page_registers (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  port,
  input  logic [7:0]  write_data,
  input  logic [2:0]  channel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [23:0] phys_addr,
  output logic        transferred,
  output logic [1:0]  unit_bytes,
  output logic        terminal_count,
  output logic        channel_stopped,
  output logic [17:0] remaining_bytes
);

  ddma_pkg::item_t item;
  logic            item_valid;
  logic            stage_adv;
  ddma_pkg::dec_t  dec;
  ddma_pkg::res_t  res_next;
  ddma_pkg::res_t  res;

  // The staged word moves on when the result register is empty or drains.
  assign stage_adv = item_valid && (!out_valid || out_ready);
  assign in_ready  = !item_valid || stage_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.command    <= command;
      item.port       <= port;
      item.write_data <= write_data;
      item.channel    <= channel;
    end
  end

  ddma_decode u_decode (
    .port (item.port),
    .dec  (dec)
  );

  ddma_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (stage_adv),
    .item (item),
    .dec  (dec),
    .res  (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      res <= res_next;
    end
  end

  assign read_data       = res.read_data;
  assign phys_addr       = res.phys_addr;
  assign transferred     = res.transferred;
  assign unit_bytes      = res.unit_bytes;
  assign terminal_count  = res.terminal_count;
  assign channel_stopped = res.channel_stopped;
  assign remaining_bytes = res.remaining_bytes;

`ifndef ASSERT_OFF
  // A word that leaves the input register shows up as a result.
  a_adv_out: assert property (@(posedge clk) disable iff (rst)
    stage_adv |=> out_valid)
    else $error("advanced word produced no result");

  // A staged word that cannot advance stays staged.
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !stage_adv |=> item_valid)
    else $error("staged word lost");

  // A self-stop only happens on a real transfer at terminal count.
  a_stop_tc: assert property (@(posedge clk) disable iff (rst)
    out_valid && channel_stopped |-> terminal_count && transferred)
    else $error("stop without terminal count");

  // A moved unit is one byte or one word.
  a_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid && transferred |-> unit_bytes == 2'd1 || unit_bytes == 2'd2)
    else $error("bad unit size");
`endif

endmodule

### sim/ddma_checker.sv
// Checker for the dual DMA controller: predicts every result from the accepted
// input words and compares it with what the block returns. Depends on ddma_pkg.
module ddma_checker
  import ddma_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  command,
  input  logic [7:0]  port,
  input  logic [7:0]  write_data,
  input  logic [2:0]  channel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  read_data,
  input  logic [23:0] phys_addr,
  input  logic        transferred,
  input  logic [1:0]  unit_bytes,
  input  logic        terminal_count,
  input  logic        channel_stopped,
  input  logic [17:0] remaining_bytes,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Mirror of the channel registers of both controllers.
  logic [15:0] load_addr [8];
  logic [15:0] base_cnt  [8];
  logic [15:0] run_addr  [8];
  logic [15:0] cur_cnt   [8];
  logic [7:0]  page_reg  [8];
  logic [7:0]  mode_reg  [8];
  logic        masked    [8];
  logic        tc_flag   [8];
  logic        flip_flop [2];
  logic [7:0]  cmd_reg   [2];

  res_t pending_results[$];
  int   results_seen = 0;

  // Channel behind a page register port, or -1 for the unused ones.
  function automatic int page_channel(input logic [7:0] p);
    case (p)
      PAGE_PORT_CH0: return 0;
      PAGE_PORT_CH1: return 1;
      PAGE_PORT_CH2: return 2;
      PAGE_PORT_CH3: return 3;
      PAGE_PORT_CH5: return 5;
      PAGE_PORT_CH6: return 6;
      PAGE_PORT_CH7: return 7;
      default: return -1;
    endcase
  endfunction

  // Applies one input word to the mirrored registers and returns its result.
  task automatic dma_access(input item_t w, output res_t r);
    int          pc;
    logic        hit;
    logic        ctl;
    logic [3:0]  regno;
    logic [2:0]  ch;
    logic [15:0] sel;
    logic [17:0] unit;
    r = '0;
    pc = page_channel(w.port);
    hit = 1'b0;
    ctl = 1'b0;
    regno = '0;
    if (w.port <= 8'h0F) begin
      hit = 1'b1;
      regno = w.port[3:0];
    end else if (w.port >= 8'hC0 && w.port <= 8'hDF) begin
      hit = 1'b1;
      ctl = 1'b1;
      regno = w.port[4:1];
    end
    ch = {ctl, regno[2:1]};
    case (w.command)
      CMD_WRITE: begin
        if (w.port[7:4] == 4'h8) begin
          if (pc >= 0) page_reg[pc] = w.write_data;
        end else if (hit && !regno[3]) begin
          // Address and count halves go through the byte pointer.
          if (regno[0]) begin
            if (flip_flop[ctl]) base_cnt[ch][15:8] = w.write_data;
            else base_cnt[ch][7:0] = w.write_data;
            cur_cnt[ch] = base_cnt[ch];
          end else begin
            if (flip_flop[ctl]) load_addr[ch][15:8] = w.write_data;
            else load_addr[ch][7:0] = w.write_data;
            run_addr[ch] = load_addr[ch];
          end
          flip_flop[ctl] = ~flip_flop[ctl];
        end else if (hit) begin
          case (regno)
            REG_CMD: cmd_reg[ctl] = w.write_data;
            REG_MASK: masked[{ctl, w.write_data[1:0]}] = w.write_data[2];
            REG_MODE: mode_reg[{ctl, w.write_data[1:0]}] = w.write_data;
            REG_CLR_BP: flip_flop[ctl] = 1'b0;
            REG_MCLR: begin
              flip_flop[ctl] = 1'b0;
              cmd_reg[ctl] = '0;
              for (int i = 0; i < 4; i++) begin
                masked[ctl * 4 + i] = 1'b1;
                tc_flag[ctl * 4 + i] = 1'b0;
              end
            end
            REG_CLR_MASKS: for (int i = 0; i < 4; i++) masked[ctl * 4 + i] = 1'b0;
            REG_ALL_MASKS:
              for (int i = 0; i < 4; i++) masked[ctl * 4 + i] = w.write_data[i];
            default: ;
          endcase
        end
      end
      CMD_READ: begin
        if (w.port[7:4] == 4'h8) begin
          r.read_data = (pc >= 0) ? page_reg[pc] : UNMAPPED_DATA;
        end else if (hit && !regno[3]) begin
          sel = regno[0] ? cur_cnt[ch] : run_addr[ch];
          r.read_data = flip_flop[ctl] ? sel[15:8] : sel[7:0];
          flip_flop[ctl] = ~flip_flop[ctl];
        end else if (hit && regno == REG_CMD) begin
          // Status read returns and clears the controller's TC bits.
          for (int i = 0; i < 4; i++) begin
            r.read_data[i] = tc_flag[ctl * 4 + i];
            tc_flag[ctl * 4 + i] = 1'b0;
          end
        end else begin
          r.read_data = UNMAPPED_DATA;
        end
      end
      CMD_XFER: begin
        ch = w.channel;
        unit = ch[2] ? 18'd2 : 18'd1;
        if (!masked[ch]) begin
          if (ch[2]) r.phys_addr = {page_reg[ch][7:1], run_addr[ch], 1'b0};
          else r.phys_addr = {page_reg[ch], run_addr[ch]};
          r.transferred = 1'b1;
          r.unit_bytes = unit[1:0];
          if (mode_reg[ch][MODE_DECREMENT_BIT]) run_addr[ch] = run_addr[ch] - 16'd1;
          else run_addr[ch] = run_addr[ch] + 16'd1;
          if (cur_cnt[ch] == 16'd0) begin
            tc_flag[ch] = 1'b1;
            r.terminal_count = 1'b1;
            if (mode_reg[ch][MODE_AUTOINIT_BIT]) begin
              run_addr[ch] = load_addr[ch];
              cur_cnt[ch] = base_cnt[ch];
            end else begin
              masked[ch] = 1'b1;
              r.channel_stopped = 1'b1;
            end
          end else begin
            cur_cnt[ch] = cur_cnt[ch] - 16'd1;
          end
        end
        r.remaining_bytes = ({2'b00, cur_cnt[ch]} + 18'd1) * unit;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [23:0] want, input logic [23:0] got);
    if (want !== got) begin
      if (errors < 10)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, field, want, got);
      errors++;
    end
  endtask

  // Results are compared before new words are predicted; the block's latency
  // keeps a word from returning on the edge that accepts it.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        load_addr[i] = '0;
        base_cnt[i] = '0;
        run_addr[i] = '0;
        cur_cnt[i] = '0;
        page_reg[i] = '0;
        mode_reg[i] = '0;
        masked[i] = 1'b1;
        tc_flag[i] = 1'b0;
      end
      flip_flop[0] = 1'b0;
      flip_flop[1] = 1'b0;
      cmd_reg[0] = '0;
      cmd_reg[1] = '0;
      errors = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          if (errors < 10) $display("result %0d arrived with nothing expected", results_seen);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_data", want.read_data, read_data);
          check_field("phys_addr", want.phys_addr, phys_addr);
          check_field("transferred", want.transferred, transferred);
          check_field("unit_bytes", want.unit_bytes, unit_bytes);
          check_field("terminal_count", want.terminal_count, terminal_count);
          check_field("channel_stopped", want.channel_stopped, channel_stopped);
          check_field("remaining_bytes", want.remaining_bytes, remaining_bytes);
        end
        results_seen++;
      end
      if (in_valid && in_ready) begin
        dma_access(item_t'{command: command, port: port, write_data: write_data,
                           channel: channel}, want);
        pending_results.push_back(want);
      end
    end
    pending <= pending_results.size();
  end

endmodule

### sim/tb_dual_dma_controller_with_page_registers.sv
// Testbench top for the dual DMA controller: clock, reset, word stimulus with
// bursty sending and stalled receiving. Depends on ddma_pkg and ddma_checker.
module tb_dual_dma_controller_with_page_registers;
  timeunit 1ns;
  timeprecision 1ps;
  import ddma_pkg::*;

  localparam logic [1:0] CMD_UNUSED       = 2'd3;
  localparam logic [7:0] UNUSED_PAGE_PORT = 8'h8F;
  localparam int         WORD_TARGET      = 750;
  localparam int         CYCLE_LIMIT      = 200000;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_PERIODIC
  } ready_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = '0;
  logic [7:0]  port = '0;
  logic [7:0]  write_data = '0;
  logic [2:0]  channel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data;
  logic [23:0] phys_addr;
  logic        transferred;
  logic [1:0]  unit_bytes;
  logic        terminal_count;
  logic        channel_stopped;
  logic [17:0] remaining_bytes;

  int          errors;
  int          pending;
  int          cycle_count = 0;
  int          sent_words = 0;
  int          burst_left = 0;
  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_timer = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_dma_controller_with_page_registers u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .port(port), .write_data(write_data), .channel(channel),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .phys_addr(phys_addr), .transferred(transferred),
    .unit_bytes(unit_bytes), .terminal_count(terminal_count),
    .channel_stopped(channel_stopped), .remaining_bytes(remaining_bytes)
  );

  ddma_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .port(port), .write_data(write_data), .channel(channel),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_data(read_data), .phys_addr(phys_addr), .transferred(transferred),
    .unit_bytes(unit_bytes), .terminal_count(terminal_count),
    .channel_stopped(channel_stopped), .remaining_bytes(remaining_bytes),
    .errors(errors), .pending(pending)
  );

  // The receiver switches between stall patterns whenever its timer runs out.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_timer <= 0;
    end else begin
      if (ready_timer == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        ready_timer <= $urandom_range(16, 96);
      end else begin
        ready_timer <= ready_timer - 1;
      end
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN: out_ready <= 1'($urandom);
        READY_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (ready_timer[2:0] != 3'd0);
      endcase
    end
  end

  // Port of a controller register; the second controller picks either alias.
  function automatic logic [7:0] ctl_port(input logic ctl, input logic [3:0] regno);
    if (ctl) return {3'b110, regno, 1'($urandom)};
    return {4'h0, regno};
  endfunction

  function automatic logic [7:0] page_port(input logic [2:0] ch);
    case (ch)
      3'd0: return PAGE_PORT_CH0;
      3'd1: return PAGE_PORT_CH1;
      3'd2: return PAGE_PORT_CH2;
      3'd3: return PAGE_PORT_CH3;
      3'd5: return PAGE_PORT_CH5;
      3'd6: return PAGE_PORT_CH6;
      3'd7: return PAGE_PORT_CH7;
      default: return UNUSED_PAGE_PORT;
    endcase
  endfunction

  // Sends one word; a new burst may open with an idle gap.
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] p,
                           input logic [7:0] d, input logic [2:0] ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    command <= cmd;
    port <= p;
    write_data <= d;
    channel <= ch;
    do @(posedge clk); while (!in_ready);
    sent_words++;
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // A well-formed channel setup followed by transfers and register reads.
  task automatic program_channel(input logic [2:0] ch);
    logic [15:0] addr;
    logic [15:0] cnt;
    logic [7:0]  mode;
    int          steps;
    addr = ($urandom_range(0, 3) == 0) ? {16{1'($urandom)}} : 16'($urandom);
    cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    mode = {2'($urandom), 1'($urandom), 1'($urandom), 2'($urandom), ch[1:0]};
    send_word(CMD_WRITE, ctl_port(ch[2], REG_CLR_BP), 8'($urandom), 3'($urandom));
    send_word(CMD_WRITE, ctl_port(ch[2], {1'b0, ch[1:0], 1'b0}), addr[7:0], 3'($urandom));
    send_word(CMD_WRITE, ctl_port(ch[2], {1'b0, ch[1:0], 1'b0}), addr[15:8], 3'($urandom));
    send_word(CMD_WRITE, ctl_port(ch[2], {1'b0, ch[1:0], 1'b1}), cnt[7:0], 3'($urandom));
    send_word(CMD_WRITE, ctl_port(ch[2], {1'b0, ch[1:0], 1'b1}), cnt[15:8], 3'($urandom));
    send_word(CMD_WRITE, page_port(ch), 8'($urandom), 3'($urandom));
    send_word(CMD_WRITE, ctl_port(ch[2], REG_MODE), mode, 3'($urandom));
    send_word(CMD_WRITE, ctl_port(ch[2], REG_MASK),
              {5'($urandom), 1'b0, ch[1:0]}, 3'($urandom));
    steps = $urandom_range(1, 7);
    for (int i = 0; i < steps; i++) begin
      send_word(CMD_XFER, 8'($urandom), 8'($urandom),
                ($urandom_range(0, 5) == 0) ? 3'($urandom) : ch);
      case ($urandom_range(0, 7))
        0: send_word(CMD_READ, ctl_port(ch[2], {1'b0, ch[1:0], 1'($urandom)}),
                     8'($urandom), 3'($urandom));
        1: send_word(CMD_READ, ctl_port(ch[2], REG_CMD), 8'($urandom), 3'($urandom));
        2: send_word(CMD_READ, page_port(ch), 8'($urandom), 3'($urandom));
        default: ;
      endcase
    end
  endtask

  // Random words, biased toward the mapped port ranges.
  task automatic send_noise();
    logic [7:0] p;
    case ($urandom_range(0, 3))
      0: p = 8'($urandom);
      1: p = {4'h0, 4'($urandom)};
      2: p = {3'b110, 5'($urandom)};
      default: p = {4'h8, 4'($urandom)};
    endcase
    send_word(2'($urandom), p, 8'($urandom), 3'($urandom));
  endtask

  // Run watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int  target;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset state, masked channel, unmapped ports, unused command.
    send_word(CMD_XFER, 8'h00, 8'h00, 3'd0);
    send_word(CMD_READ, ctl_port(1'b0, REG_CMD), 8'h00, 3'd0);
    send_word(CMD_READ, UNUSED_PAGE_PORT, 8'h00, 3'd0);
    send_word(CMD_READ, 8'h20, 8'h00, 3'd0);
    send_word(CMD_READ, ctl_port(1'b0, REG_REQ), 8'h00, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b0, REG_REQ), 8'hFF, 3'd0);
    send_word(CMD_UNUSED, 8'hFF, 8'hFF, 3'd7);

    // Channel 1 at address 0xFFFF, two units, no autoinit: wraps, then stops.
    send_word(CMD_WRITE, ctl_port(1'b0, REG_CLR_BP), 8'h00, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b0, 4'd2), 8'hFF, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b0, 4'd2), 8'hFF, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b0, 4'd3), 8'h01, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b0, 4'd3), 8'h00, 3'd0);
    send_word(CMD_WRITE, PAGE_PORT_CH1, 8'hFF, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b0, REG_MODE), 8'h01, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b0, REG_MASK), 8'h01, 3'd0);
    send_word(CMD_XFER, 8'h00, 8'h00, 3'd1);
    send_word(CMD_XFER, 8'h00, 8'h00, 3'd1);
    send_word(CMD_XFER, 8'h00, 8'h00, 3'd1);
    send_word(CMD_READ, ctl_port(1'b0, REG_CMD), 8'h00, 3'd0);

    // Channel 5 with a zero count, autoinit and decrement at page 0xFF.
    send_word(CMD_WRITE, ctl_port(1'b1, REG_MCLR), 8'h00, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b1, 4'd3), 8'h00, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b1, 4'd3), 8'h00, 3'd0);
    send_word(CMD_WRITE, PAGE_PORT_CH5, 8'hFF, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b1, REG_MODE), 8'h31, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b1, REG_CLR_MASKS), 8'h00, 3'd0);
    send_word(CMD_XFER, 8'h00, 8'h00, 3'd5);
    send_word(CMD_READ, ctl_port(1'b1, 4'd2), 8'h00, 3'd0);
    send_word(CMD_WRITE, ctl_port(1'b1, REG_ALL_MASKS), 8'h0F, 3'd0);
    send_word(CMD_XFER, 8'hFF, 8'hFF, 3'd7);
    send_word(CMD_READ, ctl_port(1'b1, REG_CMD), 8'h00, 3'd0);
    wait_drained();

    // Random part: mostly channel setups with transfers, some noise.
    target = sent_words + WORD_TARGET;
    while (sent_words < target) begin
      if ($urandom_range(0, 9) < 7) begin
        program_channel(3'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) send_noise();
      end
      if (sent_words >= target - WORD_TARGET / 2 && sent_words < target - WORD_TARGET / 2 + 20)
        wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### dual_dma_controller_with_page_registers.f
hw/rtl/ddma_pkg.sv
hw/rtl/ddma_decode.sv
hw/rtl/ddma_core.sv
hw/rtl/dual_dma_controller_with_page_registers.sv
sim/ddma_checker.sv
sim/tb_dual_dma_controller_with_page_registers.sv
